FILE: hdl/grrh_pkg.sv
// grrh_pkg: shared types and codes for the gate request/reply handshake block
// no dependencies; imported by the top level and its assertion checker
`default_nettype none

package grrh_pkg;

  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_ENTRY = 2'd1;
  localparam logic [1:0] KIND_EXIT  = 2'd2;

  localparam logic [2:0] ACT_SEND_A     = 3'd0;
  localparam logic [2:0] ACT_SEND_B     = 3'd1;
  localparam logic [2:0] ACT_OPEN_ENTRY = 3'd2;
  localparam logic [2:0] ACT_DENY_ENTRY = 3'd3;
  localparam logic [2:0] ACT_OPEN_EXIT  = 3'd4;
  localparam logic [2:0] ACT_DENY_EXIT  = 3'd5;

  localparam logic [1:0] REPLY_NONE  = 2'd0;
  localparam logic [1:0] REPLY_DENY  = 2'd1;
  localparam logic [1:0] REPLY_GRANT = 2'd2;

  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_LOW   = 8'd32;
  localparam logic [7:0] CHAR_HIGH  = 8'd126;
  localparam logic [7:0] CHAR_E     = 8'h45;
  localparam logic [7:0] CHAR_N     = 8'h4E;
  localparam logic [7:0] CHAR_X     = 8'h58;
  localparam logic [7:0] CHAR_A     = 8'h41;

  typedef struct packed {
    logic exa;
    logic ex;
    logic ena;
    logic en;
  } match_flags_t;

  typedef struct packed {
    logic [2:0] action;
    logic       last;
  } result_t;

  localparam int QUEUE_DEPTH = 3;

endpackage

`default_nettype wire

FILE: hdl/gate_request_reply_handshake_top.sv
// gate request/reply handshake: accepted transactions enter a registered result queue;
// one transaction per cycle while each gives at most one result and out_stall is low;
// a transaction with two results leaves through the single-entry-per-cycle result queue
// (3 entries, input stalls once more than one result is queued)
// rst (synchronous) clears line state, waiting flags, stored replies and the queue
// depends on grrh_pkg
`default_nettype none

module gate_request_reply_handshake_top #(
  parameter int MAX_LINE = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] kind,
  input  wire logic [7:0] rx_byte,
  input  wire logic       detected,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      action,
  output logic            last
);
  import grrh_pkg::*;

  localparam int LEN_W = $clog2(MAX_LINE + 1);

  logic [LEN_W-1:0] line_length, line_length_next;
  logic [7:0]       prev_char, prev_char_next;
  logic [7:0]       prev_prev_char, prev_prev_char_next;
  match_flags_t     match_flags, match_flags_next;
  logic             entry_waiting, entry_waiting_next;
  logic             exit_waiting, exit_waiting_next;
  logic [1:0]       entry_reply, entry_reply_next;
  logic [1:0]       exit_reply, exit_reply_next;

  result_t          queue [QUEUE_DEPTH];
  result_t          queue_next [QUEUE_DEPTH];
  logic [1:0]       count, count_next;
  logic [1:0]       base;
  logic             accept, pop;
  logic [1:0]       n_res;
  result_t          res0, res1;

  assign in_stall  = (count > 2'd1);
  assign accept    = in_valid && !in_stall;
  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign action    = queue[0].action;
  assign last      = queue[0].last;

  always_comb begin
    line_length_next    = line_length;
    prev_char_next      = prev_char;
    prev_prev_char_next = prev_prev_char;
    match_flags_next    = match_flags;
    entry_waiting_next  = entry_waiting;
    exit_waiting_next   = exit_waiting;
    entry_reply_next    = entry_reply;
    exit_reply_next     = exit_reply;
    n_res = 2'd0;
    res0  = '0;
    res1  = '0;
    if (accept) begin
      unique case (kind)
        KIND_BYTE: begin
          if (rx_byte == CHAR_CR || rx_byte == CHAR_LF) begin
            if (line_length != '0) begin
              line_length_next    = '0;
              prev_char_next      = '0;
              prev_prev_char_next = '0;
              match_flags_next    = '0;
              if (match_flags.en) begin
                if (entry_waiting) begin
                  entry_waiting_next = 1'b0;
                  entry_reply_next   = REPLY_NONE;
                  n_res = 2'd1;
                  res0  = '{action: match_flags.ena ? ACT_OPEN_ENTRY : ACT_DENY_ENTRY,
                            last: 1'b1};
                end else begin
                  entry_reply_next = match_flags.ena ? REPLY_GRANT : REPLY_DENY;
                end
              end else if (match_flags.ex) begin
                if (exit_waiting) begin
                  exit_waiting_next = 1'b0;
                  exit_reply_next   = REPLY_NONE;
                  n_res = 2'd1;
                  res0  = '{action: match_flags.exa ? ACT_OPEN_EXIT : ACT_DENY_EXIT,
                            last: 1'b1};
                end else begin
                  exit_reply_next = match_flags.exa ? REPLY_GRANT : REPLY_DENY;
                end
              end
            end
          end else if (rx_byte >= CHAR_LOW && rx_byte <= CHAR_HIGH
                       && line_length < LEN_W'(MAX_LINE)) begin
            if (prev_char == CHAR_E && rx_byte == CHAR_N) match_flags_next.en = 1'b1;
            if (prev_char == CHAR_E && rx_byte == CHAR_X) match_flags_next.ex = 1'b1;
            if (prev_prev_char == CHAR_E && prev_char == CHAR_N && rx_byte == CHAR_A)
              match_flags_next.ena = 1'b1;
            if (prev_prev_char == CHAR_E && prev_char == CHAR_X && rx_byte == CHAR_A)
              match_flags_next.exa = 1'b1;
            prev_prev_char_next = prev_char;
            prev_char_next      = rx_byte;
            line_length_next    = line_length + LEN_W'(1);
          end
        end
        KIND_ENTRY: begin
          if (!entry_waiting && detected) begin
            if (entry_reply != REPLY_NONE) begin
              entry_reply_next = REPLY_NONE;
              n_res = 2'd2;
              res0  = '{action: ACT_SEND_A, last: 1'b0};
              res1  = '{action: (entry_reply >= REPLY_GRANT) ? ACT_OPEN_ENTRY
                                                             : ACT_DENY_ENTRY,
                        last: 1'b1};
            end else begin
              entry_waiting_next = 1'b1;
              n_res = 2'd1;
              res0  = '{action: ACT_SEND_A, last: 1'b1};
            end
          end
        end
        KIND_EXIT: begin
          if (!exit_waiting && detected) begin
            if (exit_reply != REPLY_NONE) begin
              exit_reply_next = REPLY_NONE;
              n_res = 2'd2;
              res0  = '{action: ACT_SEND_B, last: 1'b0};
              res1  = '{action: (exit_reply >= REPLY_GRANT) ? ACT_OPEN_EXIT
                                                            : ACT_DENY_EXIT,
                        last: 1'b1};
            end else begin
              exit_waiting_next = 1'b1;
              n_res = 2'd1;
              res0  = '{action: ACT_SEND_B, last: 1'b1};
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // result queue, head entry drives the output ports
  always_comb begin
    base = count - {1'b0, pop};
    if (pop) begin
      queue_next[0] = queue[1];
      queue_next[1] = queue[2];
      queue_next[2] = queue[2];
    end else begin
      queue_next[0] = queue[0];
      queue_next[1] = queue[1];
      queue_next[2] = queue[2];
    end
    if (n_res != 2'd0) queue_next[base] = res0;
    if (n_res == 2'd2) queue_next[base + 2'd1] = res1;
    count_next = base + n_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length    <= '0;
      prev_char      <= '0;
      prev_prev_char <= '0;
      match_flags    <= '0;
      entry_waiting  <= 1'b0;
      exit_waiting   <= 1'b0;
      entry_reply    <= REPLY_NONE;
      exit_reply     <= REPLY_NONE;
      count          <= 2'd0;
    end else begin
      line_length    <= line_length_next;
      prev_char      <= prev_char_next;
      prev_prev_char <= prev_prev_char_next;
      match_flags    <= match_flags_next;
      entry_waiting  <= entry_waiting_next;
      exit_waiting   <= exit_waiting_next;
      entry_reply    <= entry_reply_next;
      exit_reply     <= exit_reply_next;
      count          <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      queue[i] <= queue_next[i];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/grrh_checker.sv
// grrh_checker: port-level assertions for gate_request_reply_handshake_top
// depends on grrh_pkg; attached to the top level by the bind at the end of this file
`default_nettype none

module grrh_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [2:0] action,
  input wire logic       last
);
  import grrh_pkg::*;

  // a stalled result transaction stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result transaction dropped while stalled");

  // a stalled result does not change
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(action) && $stable(last))
    else $error("stalled result changed");

  // an empty output side never holds off input
  a_empty_accepts: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with no result pending");

  // only defined action codes leave the block
  a_action_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> action <= ACT_DENY_EXIT)
    else $error("undefined action code");

  // reset empties the result queue
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind gate_request_reply_handshake_top grrh_checker u_grrh_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .action    (action),
  .last      (last)
);

`default_nettype wire

FILE: verif/gate_request_reply_handshake_top_test.sv
// self-checking testbench for gate_request_reply_handshake_top: directed table, then random traffic
// in four idle/stall mixes, results checked against typed rows or an in-file gate-logic predictor
// depends on grrh_pkg and the gate_request_reply_handshake_top rtl
`default_nettype none

module gate_request_reply_handshake_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import grrh_pkg::*;

  localparam int LINE_MAX = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEMS_PER_PHASE = 225;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] rx;
    logic       det;
    logic       typed;
    logic [1:0] count;
    logic [2:0] act0;
    logic [2:0] act1;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] kind = KIND_BYTE;
  logic [7:0] rx_byte = 8'd0;
  logic       detected = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] action;
  logic       last;

  // predictor state
  int           line_len;
  logic [7:0]   prev_ch;
  logic [7:0]   prev2_ch;
  match_flags_t line_flags;
  logic         side_waiting [0:1];
  logic [1:0]   side_reply [0:1];
  int           gate_result_count;
  logic [2:0]   gate_act0;
  logic [2:0]   gate_act1;

  result_t   expected_results [$];
  stim_row_t directed_rows [$];
  int        send_idle = 0;
  int        recv_stall = 0;
  int        items_sent = 0;
  int        results_seen = 0;
  int        errors = 0;
  int        cycle_count = 0;

  gate_request_reply_handshake_top #(.MAX_LINE(LINE_MAX)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .rx_byte(rx_byte), .detected(detected),
    .out_valid(out_valid), .out_stall(out_stall),
    .action(action), .last(last)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected", cycle_count,
               expected_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= (recv_stall > 0) && ($urandom_range(99) < recv_stall);
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    errors++;
  endtask

  // gate behavior for one accepted transaction
  function automatic void predict_gate(input logic [1:0] k, input logic [7:0] b, input logic d);
    match_flags_t f;
    int s;
    logic grant;
    gate_result_count = 0;
    gate_act0 = ACT_SEND_A;
    gate_act1 = ACT_SEND_A;
    if (k == KIND_BYTE) begin
      if (b == CHAR_CR || b == CHAR_LF) begin
        if (line_len != 0) begin
          f = line_flags;
          line_len = 0;
          prev_ch = 8'd0;
          prev2_ch = 8'd0;
          line_flags = '0;
          if (f.en || f.ex) begin
            s = f.en ? 0 : 1;
            grant = f.en ? f.ena : f.exa;
            if (side_waiting[s]) begin
              side_waiting[s] = 1'b0;
              side_reply[s] = REPLY_NONE;
              gate_act0 = grant ? (s ? ACT_OPEN_EXIT : ACT_OPEN_ENTRY)
                                : (s ? ACT_DENY_EXIT : ACT_DENY_ENTRY);
              gate_result_count = 1;
            end else begin
              side_reply[s] = grant ? REPLY_GRANT : REPLY_DENY;
            end
          end
        end
      end else if (b >= CHAR_LOW && b <= CHAR_HIGH && line_len < LINE_MAX) begin
        if (prev_ch == CHAR_E && b == CHAR_N) line_flags.en = 1'b1;
        if (prev_ch == CHAR_E && b == CHAR_X) line_flags.ex = 1'b1;
        if (prev2_ch == CHAR_E && prev_ch == CHAR_N && b == CHAR_A) line_flags.ena = 1'b1;
        if (prev2_ch == CHAR_E && prev_ch == CHAR_X && b == CHAR_A) line_flags.exa = 1'b1;
        prev2_ch = prev_ch;
        prev_ch = b;
        line_len++;
      end
    end else if (k == KIND_ENTRY || k == KIND_EXIT) begin
      s = (k == KIND_EXIT) ? 1 : 0;
      if (!side_waiting[s] && d) begin
        gate_act0 = s ? ACT_SEND_B : ACT_SEND_A;
        gate_result_count = 1;
        side_waiting[s] = 1'b1;
        if (side_reply[s] != REPLY_NONE) begin
          gate_act1 = (side_reply[s] >= REPLY_GRANT) ? (s ? ACT_OPEN_EXIT : ACT_OPEN_ENTRY)
                                                     : (s ? ACT_DENY_EXIT : ACT_DENY_ENTRY);
          gate_result_count = 2;
          side_reply[s] = REPLY_NONE;
          side_waiting[s] = 1'b0;
        end
      end
    end
  endfunction

  task automatic send_item(input logic [1:0] k, input logic [7:0] b, input logic d,
                           input logic typed, input int n, input logic [2:0] a0,
                           input logic [2:0] a1);
    logic stalled;
    result_t r;
    if (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid <= 1'b1;
    kind <= k;
    rx_byte <= b;
    detected <= d;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    predict_gate(k, b, d);
    if (typed) begin
      gate_result_count = n;
      gate_act0 = a0;
      gate_act1 = a1;
    end
    for (int i = 0; i < gate_result_count; i++) begin
      r.action = (i == 0) ? gate_act0 : gate_act1;
      r.last = (i == gate_result_count - 1);
      expected_results.push_back(r);
    end
    if (k != KIND_SPARE) items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(KIND_BYTE, b, 1'($urandom_range(1)), 1'b0, 0, ACT_SEND_A, ACT_SEND_A);
  endtask

  // reply line: printable filler, a keyword with stray bytes mixed in, more filler, then cr or lf
  task automatic send_line();
    int pre;
    string tok;
    pre = ($urandom_range(99) < 10) ? $urandom_range(12, 18) : $urandom_range(0, 3);
    repeat (pre) send_byte(8'($urandom_range(CHAR_LOW, CHAR_HIGH)));
    case ($urandom_range(0, 7))
      0: tok = "EN";
      1: tok = "ENA";
      2: tok = "EX";
      3: tok = "EXA";
      4: tok = "ENEXA";
      5: tok = "EXEN";
      6: tok = "E";
      default: tok = "NA";
    endcase
    for (int i = 0; i < tok.len(); i++) begin
      if ($urandom_range(99) < 8)
        send_byte(($urandom_range(1) == 1) ? 8'($urandom_range(0, 9))
                                           : 8'($urandom_range(127, 255)));
      send_byte(tok[i]);
    end
    repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(CHAR_LOW, CHAR_HIGH)));
    send_byte(($urandom_range(1) == 1) ? CHAR_CR : CHAR_LF);
  endtask

  function automatic stim_row_t mk_row(input logic [1:0] k, input logic [7:0] b, input logic d,
                                       input logic typed, input int n,
                                       input logic [2:0] a0, input logic [2:0] a1);
    stim_row_t row;
    row.kind = k;
    row.rx = b;
    row.det = d;
    row.typed = typed;
    row.count = 2'(n);
    row.act0 = a0;
    row.act1 = a1;
    return row;
  endfunction

  always @(negedge clk) begin
    result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result action=%0d last=%0d", action, last));
      end else begin
        exp_r = expected_results.pop_front();
        if (action !== exp_r.action)
          report_mismatch($sformatf("action %0d, expected %0d", action, exp_r.action));
        if (last !== exp_r.last)
          report_mismatch($sformatf("last %0d, expected %0d", last, exp_r.last));
      end
    end
  end

  initial begin
    int target;
    int roll;
    line_len = 0;
    prev_ch = 8'd0;
    prev2_ch = 8'd0;
    line_flags = '0;
    side_waiting[0] = 1'b0;
    side_waiting[1] = 1'b0;
    side_reply[0] = REPLY_NONE;
    side_reply[1] = REPLY_NONE;

    directed_rows.push_back(mk_row(KIND_ENTRY, 8'h00, 1'b0, 1'b1, 0, ACT_SEND_A, ACT_SEND_A));
    directed_rows.push_back(mk_row(KIND_SPARE, 8'hFF, 1'b1, 1'b1, 0, ACT_SEND_A, ACT_SEND_A));
    directed_rows.push_back(mk_row(KIND_ENTRY, 8'h00, 1'b1, 1'b1, 1, ACT_SEND_A, ACT_SEND_A));
    directed_rows.push_back(mk_row(KIND_ENTRY, 8'hFF, 1'b1, 1'b1, 0, ACT_SEND_A, ACT_SEND_A));
    directed_rows.push_back(mk_row(KIND_BYTE, CHAR_LOW, 1'b0, 1'b0, 0, ACT_SEND_A, ACT_SEND_A));
    directed_rows.push_back(mk_row(KIND_BYTE, CHAR_E, 1'b0, 1'b0, 0, ACT_SEND_A, ACT_SEND_A));
    directed_rows.push_back(mk_row(KIND_BYTE, 8'h00, 1'b1, 1'b0, 0, ACT_SEND_A, ACT_SEND_A));
    directed_rows.push_back(mk_row(KIND_BYTE, CHAR_N, 1'b0, 1'b0, 0, ACT_SEND_A, ACT_SEND_A));
    directed_rows.push_back(mk_row(KIND_BYTE, 8'hFF, 1'b0, 1'b0, 0, ACT_SEND_A, ACT_SEND_A));
    directed_rows.push_back(mk_row(KIND_BYTE, CHAR_A, 1'b0, 1'b0, 0, ACT_SEND_A, ACT_SEND_A));
    directed_rows.push_back(mk_row(KIND_BYTE, CHAR_CR, 1'b0, 1'b1, 1, ACT_OPEN_ENTRY,
                                   ACT_SEND_A));
    directed_rows.push_back(mk_row(KIND_BYTE, CHAR_LF, 1'b0, 1'b1, 0, ACT_SEND_A, ACT_SEND_A));
    directed_rows.push_back(mk_row(KIND_EXIT, 8'h00, 1'b1, 1'b1, 1, ACT_SEND_B, ACT_SEND_A));
    directed_rows.push_back(mk_row(KIND_BYTE, CHAR_E, 1'b0, 1'b0, 0, ACT_SEND_A, ACT_SEND_A));
    directed_rows.push_back(mk_row(KIND_BYTE, CHAR_X, 1'b0, 1'b0, 0, ACT_SEND_A, ACT_SEND_A));
    directed_rows.push_back(mk_row(KIND_BYTE, CHAR_HIGH, 1'b0, 1'b0, 0, ACT_SEND_A, ACT_SEND_A));
    directed_rows.push_back(mk_row(KIND_BYTE, CHAR_LF, 1'b0, 1'b1, 1, ACT_DENY_EXIT,
                                   ACT_SEND_A));
    directed_rows.push_back(mk_row(KIND_BYTE, CHAR_E, 1'b0, 1'b0, 0, ACT_SEND_A, ACT_SEND_A));
    directed_rows.push_back(mk_row(KIND_BYTE, CHAR_N, 1'b0, 1'b0, 0, ACT_SEND_A, ACT_SEND_A));
    directed_rows.push_back(mk_row(KIND_BYTE, CHAR_CR, 1'b0, 1'b1, 0, ACT_SEND_A, ACT_SEND_A));
    directed_rows.push_back(mk_row(KIND_ENTRY, 8'h00, 1'b1, 1'b1, 2, ACT_SEND_A,
                                   ACT_DENY_ENTRY));
    directed_rows.push_back(mk_row(KIND_BYTE, CHAR_E, 1'b0, 1'b0, 0, ACT_SEND_A, ACT_SEND_A));
    directed_rows.push_back(mk_row(KIND_BYTE, CHAR_X, 1'b0, 1'b0, 0, ACT_SEND_A, ACT_SEND_A));
    directed_rows.push_back(mk_row(KIND_BYTE, CHAR_A, 1'b0, 1'b0, 0, ACT_SEND_A, ACT_SEND_A));
    directed_rows.push_back(mk_row(KIND_BYTE, CHAR_LF, 1'b0, 1'b1, 0, ACT_SEND_A, ACT_SEND_A));
    directed_rows.push_back(mk_row(KIND_EXIT, 8'h00, 1'b1, 1'b1, 2, ACT_SEND_B, ACT_OPEN_EXIT));

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_item(directed_rows[i].kind, directed_rows[i].rx, directed_rows[i].det,
                directed_rows[i].typed, int'(directed_rows[i].count), directed_rows[i].act0,
                directed_rows[i].act1);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle = 0;  recv_stall <= 0;  end
        1: begin send_idle = 85; recv_stall <= 0;  end
        2: begin send_idle = 0;  recv_stall <= 85; end
        default: begin send_idle = 15; recv_stall <= 15; end
      endcase
      target = items_sent + ITEMS_PER_PHASE;
      while (items_sent < target) begin
        roll = $urandom_range(99);
        if (roll < 40)
          send_item(($urandom_range(1) == 1) ? KIND_EXIT : KIND_ENTRY,
                    8'($urandom_range(255)), ($urandom_range(99) < 85),
                    1'b0, 0, ACT_SEND_A, ACT_SEND_A);
        else if (roll < 85)
          send_line();
        else if (roll < 92)
          send_item(2'($urandom_range(3)), 8'($urandom_range(255)), 1'($urandom_range(1)),
                    1'b0, 0, ACT_SEND_A, ACT_SEND_A);
        else
          send_byte(($urandom_range(1) == 1) ? CHAR_CR : CHAR_LF);
      end
    end

    in_valid <= 1'b0;
    recv_stall <= 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d transactions (directed table plus four idle/stall mixes)", items_sent);
    $display("checked %0d gate results, %0d mismatches", results_seen, errors);
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
